// ===== rtl/core/register_rename_unit_defines.svh =====
// Assertion macros used by the register rename unit checker.
`ifndef REGISTER_RENAME_UNIT_DEFINES_SVH
`define REGISTER_RENAME_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define RRU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define RRU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rru_pkg.sv =====
// Shared types and constants of the register rename unit.
`default_nettype none

package rru_pkg;

	localparam int ARCH_FIELD_W = 7;
	localparam int PHYS_FIELD_W = 10;

	localparam logic KIND_RENAME  = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	localparam logic [PHYS_FIELD_W-1:0] NONE_PHYS = '1;

	typedef struct packed {
		logic                    kind;
		logic                    sa_ok;
		logic [ARCH_FIELD_W-1:0] sa;
		logic                    sb_ok;
		logic [ARCH_FIELD_W-1:0] sb;
		logic                    d_ok;
		logic [ARCH_FIELD_W-1:0] d;
		logic                    rf;
		logic                    wf;
		logic                    rel1_ok;
		logic [PHYS_FIELD_W-1:0] rel1;
		logic                    rel2_ok;
		logic [PHYS_FIELD_W-1:0] rel2;
	} rru_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/rru_front.sv =====
// Front end: accepts words, checks their register indexes and queues them.
`default_nettype none

module rru_front #(
	parameter int ARCH_REGS = 50,
	parameter int PHYS_REGS = 512
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      item_valid,
	output logic                                           item_ready,
	input  wire logic                                      kind,
	input  wire logic signed [rru_pkg::ARCH_FIELD_W-1:0]   src_a,
	input  wire logic signed [rru_pkg::ARCH_FIELD_W-1:0]   src_b,
	input  wire logic signed [rru_pkg::ARCH_FIELD_W-1:0]   dest,
	input  wire logic                                      reads_flags,
	input  wire logic                                      writes_flags,
	input  wire logic signed [rru_pkg::PHYS_FIELD_W-1:0]   release_first,
	input  wire logic signed [rru_pkg::PHYS_FIELD_W-1:0]   release_second,
	output logic                                           q_valid,
	input  wire logic                                      q_pop,
	output rru_pkg::rru_item_t                             q_item
);

	localparam int QDEPTH = 2;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	rru_pkg::rru_item_t q_mem_q [QDEPTH];
	rru_pkg::rru_item_t new_item;
	logic [QPW-1:0]     wr_ptr_q;
	logic [QPW-1:0]     rd_ptr_q;
	logic [QCW-1:0]     cnt_q;
	logic               push;

	function automatic logic arch_ok(input logic [rru_pkg::ARCH_FIELD_W-1:0] r);
		return !r[rru_pkg::ARCH_FIELD_W-1] && (int'(r) < ARCH_REGS);
	endfunction

	function automatic logic phys_ok(input logic [rru_pkg::PHYS_FIELD_W-1:0] r);
		return !r[rru_pkg::PHYS_FIELD_W-1] && (int'(r) < PHYS_REGS);
	endfunction

	always_comb begin
		new_item.kind    = kind;
		new_item.sa_ok   = arch_ok(src_a);
		new_item.sa      = src_a;
		new_item.sb_ok   = arch_ok(src_b);
		new_item.sb      = src_b;
		new_item.d_ok    = arch_ok(dest);
		new_item.d       = dest;
		new_item.rf      = reads_flags;
		new_item.wf      = writes_flags;
		new_item.rel1_ok = phys_ok(release_first);
		new_item.rel1    = release_first;
		new_item.rel2_ok = phys_ok(release_second);
		new_item.rel2    = release_second;
	end

	assign item_ready = (cnt_q != QCW'(QDEPTH));
	assign push       = item_valid && item_ready;
	assign q_valid    = (cnt_q != '0);
	assign q_item     = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (q_pop && q_valid) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			if (push && !(q_pop && q_valid)) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (!push && q_pop && q_valid) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rru_back.sv =====
// Back end: map table, free list and the sequencer that renames or releases.
`default_nettype none

module rru_back #(
	parameter int ARCH_REGS = 50,
	parameter int PHYS_REGS = 512
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     q_valid,
	output logic                                          q_pop,
	input  wire rru_pkg::rru_item_t                       q_item,
	output logic                                          result_valid,
	input  wire logic                                     result_ready,
	output logic signed [rru_pkg::PHYS_FIELD_W-1:0]       phys_src_a,
	output logic signed [rru_pkg::PHYS_FIELD_W-1:0]       phys_src_b,
	output logic signed [rru_pkg::PHYS_FIELD_W-1:0]       phys_flags_src,
	output logic signed [rru_pkg::PHYS_FIELD_W-1:0]       phys_dest,
	output logic signed [rru_pkg::PHYS_FIELD_W-1:0]       phys_flags_dest,
	output logic signed [rru_pkg::PHYS_FIELD_W-1:0]       prev_dest,
	output logic signed [rru_pkg::PHYS_FIELD_W-1:0]       prev_flags_dest,
	output logic                                          out_of_regs
);

	localparam int AW        = $clog2(ARCH_REGS);
	localparam int MAP_DEPTH = ARCH_REGS - 1;
	localparam int PW        = $clog2(PHYS_REGS);
	localparam int CW        = $clog2(PHYS_REGS + 1);
	localparam int INIT_FREE = PHYS_REGS - ARCH_REGS;
	localparam int OW        = rru_pkg::PHYS_FIELD_W;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_RD_DEST = 3'd1;
	localparam logic [2:0] ST_EXEC    = 3'd2;
	localparam logic [2:0] ST_PUSH1   = 3'd3;
	localparam logic [2:0] ST_PUSH2   = 3'd4;

	logic [2:0]         state_q;
	rru_pkg::rru_item_t cur_q;

	logic [PW-1:0] map_mem [MAP_DEPTH];
	logic          map_vld_q [MAP_DEPTH];
	logic [PW-1:0] flags_map_q;

	logic          map_a_re;
	logic [AW-1:0] map_a_addr;
	logic [PW-1:0] map_a_mem_q;
	logic          map_a_vld_q;
	logic [AW-1:0] map_a_idx_q;
	logic [PW-1:0] map_a_val;
	logic          map_b_re;
	logic [AW-1:0] map_b_addr;
	logic [PW-1:0] map_b_mem_q;
	logic          map_b_vld_q;
	logic [AW-1:0] map_b_idx_q;
	logic [PW-1:0] map_b_val;
	logic [PW-1:0] src_a_val_q;
	logic          map_we;
	logic [AW-1:0] map_waddr;

	logic [PW-1:0] fifo_mem [PHYS_REGS];
	logic [PW-1:0] head_q;
	logic [PW-1:0] head_nxt;
	logic [PW-1:0] tail_q;
	logic [PW-1:0] tail_nxt;
	logic [CW-1:0] count_q;
	logic          head_lap_q;
	logic          fifo_re;
	logic [PW-1:0] fifo_a_mem_q;
	logic [PW-1:0] fifo_b_mem_q;
	logic          fifo_a_init_q;
	logic          fifo_b_init_q;
	logic [PW-1:0] fifo_a_ival_q;
	logic [PW-1:0] fifo_b_ival_q;
	logic [PW-1:0] fifo_a_val;
	logic [PW-1:0] fifo_b_val;
	logic          fifo_we;
	logic [PW-1:0] fifo_wdata;
	logic          has_room;

	logic          out_free;
	logic          exec_go;
	logic          push2_go;
	logic          load;
	logic [1:0]    need;
	logic          enough;
	logic          commit;
	logic [PW:0]   head_sum;
	logic          head_wrap;
	logic [PW-1:0] head_new;
	logic          sa_flag;
	logic          sb_flag;
	logic          d_flag;

	logic [OW-1:0] o_src_a;
	logic [OW-1:0] o_src_b;
	logic [OW-1:0] o_flags_src;
	logic [OW-1:0] o_dest;
	logic [OW-1:0] o_flags_dest;
	logic [OW-1:0] o_prev;
	logic [OW-1:0] o_prev_flags;
	logic          o_oor;

	logic          out_valid_q;
	logic [OW-1:0] out_src_a_q;
	logic [OW-1:0] out_src_b_q;
	logic [OW-1:0] out_flags_src_q;
	logic [OW-1:0] out_dest_q;
	logic [OW-1:0] out_flags_dest_q;
	logic [OW-1:0] out_prev_q;
	logic [OW-1:0] out_prev_flags_q;
	logic          out_oor_q;

	function automatic logic in_map(input logic [rru_pkg::ARCH_FIELD_W-1:0] r);
		return int'(r) < MAP_DEPTH;
	endfunction

	function automatic logic [OW-1:0] to_out(input logic ok, input logic [PW-1:0] v);
		return ok ? OW'(v) : rru_pkg::NONE_PHYS;
	endfunction

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign out_free = !out_valid_q || result_ready;
	assign exec_go  = (state_q == ST_EXEC) && out_free;
	assign push2_go = (state_q == ST_PUSH2) && out_free;
	assign load     = exec_go || push2_go;

	assign sa_flag = (int'(cur_q.sa) == ARCH_REGS - 1);
	assign sb_flag = (int'(cur_q.sb) == ARCH_REGS - 1);
	assign d_flag  = (int'(cur_q.d) == ARCH_REGS - 1);

	// Map table reads: sources when the word is taken, destination in the cycle after.
	assign map_a_re   = (q_pop && q_item.sa_ok && in_map(q_item.sa)) ||
		((state_q == ST_RD_DEST) && cur_q.d_ok && !d_flag);
	assign map_a_addr = (state_q == ST_IDLE) ? AW'(q_item.sa) : AW'(cur_q.d);
	assign map_b_re   = q_pop && q_item.sb_ok && in_map(q_item.sb);
	assign map_b_addr = AW'(q_item.sb);

	always_ff @(posedge clk) begin
		if (map_a_re) begin
			map_a_mem_q <= map_mem[map_a_addr];
			map_a_vld_q <= map_vld_q[map_a_addr];
			map_a_idx_q <= map_a_addr;
		end
		if (map_b_re) begin
			map_b_mem_q <= map_mem[map_b_addr];
			map_b_vld_q <= map_vld_q[map_b_addr];
			map_b_idx_q <= map_b_addr;
		end
		if (map_we) begin
			map_mem[map_waddr] <= fifo_a_val;
		end
	end

	// An entry never written since reset still maps to itself.
	assign map_a_val = map_a_vld_q ? map_a_mem_q : PW'(map_a_idx_q);
	assign map_b_val = map_b_vld_q ? map_b_mem_q : PW'(map_b_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_DEPTH; i++) begin
				map_vld_q[i] <= 1'b0;
			end
		end else if (map_we) begin
			map_vld_q[map_waddr] <= 1'b1;
		end
	end

	// Free list reads at the head and the slot after it.
	assign head_nxt = (head_q == PW'(PHYS_REGS - 1)) ? '0 : head_q + PW'(1);
	assign tail_nxt = (tail_q == PW'(PHYS_REGS - 1)) ? '0 : tail_q + PW'(1);
	assign fifo_re  = q_pop && (q_item.kind == rru_pkg::KIND_RENAME);
	assign has_room = (int'(count_q) < PHYS_REGS);

	always_comb begin
		fifo_we    = 1'b0;
		fifo_wdata = PW'(cur_q.rel1);
		if (state_q == ST_PUSH1) begin
			fifo_we = cur_q.rel1_ok && has_room;
		end else if (push2_go) begin
			fifo_we    = cur_q.rel2_ok && has_room;
			fifo_wdata = PW'(cur_q.rel2);
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_re) begin
			fifo_a_mem_q <= fifo_mem[head_q];
			fifo_b_mem_q <= fifo_mem[head_nxt];
		end
		if (fifo_we) begin
			fifo_mem[tail_q] <= fifo_wdata;
		end
	end

	// On the first pass of the head, unwritten slots hold their reset contents.
	always_ff @(posedge clk) begin
		if (fifo_re) begin
			fifo_a_init_q <= !head_lap_q && (int'(head_q) < INIT_FREE);
			fifo_b_init_q <= !head_lap_q && (head_q != PW'(PHYS_REGS - 1)) &&
				(int'(head_nxt) < INIT_FREE);
			fifo_a_ival_q <= PW'(ARCH_REGS + int'(head_q));
			fifo_b_ival_q <= PW'(ARCH_REGS + int'(head_nxt));
		end
	end

	assign fifo_a_val = fifo_a_init_q ? fifo_a_ival_q : fifo_a_mem_q;
	assign fifo_b_val = fifo_b_init_q ? fifo_b_ival_q : fifo_b_mem_q;

	assign need      = {1'b0, cur_q.d_ok} + {1'b0, cur_q.wf};
	assign enough    = (CW'(need) <= count_q);
	assign commit    = exec_go && enough;
	assign head_sum  = (PW + 1)'(head_q) + (PW + 1)'(need);
	assign head_wrap = (int'(head_sum) >= PHYS_REGS);
	assign head_new  = head_wrap ? PW'(int'(head_sum) - PHYS_REGS) : PW'(head_sum);
	assign map_we    = commit && cur_q.d_ok && !d_flag;
	assign map_waddr = AW'(cur_q.d);

	always_comb begin
		o_src_a      = to_out(enough && cur_q.sa_ok, sa_flag ? flags_map_q : src_a_val_q);
		o_src_b      = to_out(enough && cur_q.sb_ok, sb_flag ? flags_map_q : map_b_val);
		o_flags_src  = to_out(enough && cur_q.rf, flags_map_q);
		o_dest       = to_out(enough && cur_q.d_ok, fifo_a_val);
		o_flags_dest = to_out(enough && cur_q.wf, cur_q.d_ok ? fifo_b_val : fifo_a_val);
		o_prev       = to_out(enough && cur_q.d_ok, d_flag ? flags_map_q : map_a_val);
		o_prev_flags = to_out(enough && cur_q.wf,
			(cur_q.d_ok && d_flag) ? fifo_a_val : flags_map_q);
		o_oor        = !enough;
		if (state_q == ST_PUSH2) begin
			o_src_a      = rru_pkg::NONE_PHYS;
			o_src_b      = rru_pkg::NONE_PHYS;
			o_flags_src  = rru_pkg::NONE_PHYS;
			o_dest       = rru_pkg::NONE_PHYS;
			o_flags_dest = rru_pkg::NONE_PHYS;
			o_prev       = rru_pkg::NONE_PHYS;
			o_prev_flags = rru_pkg::NONE_PHYS;
			o_oor        = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		if (state_q == ST_RD_DEST) begin
			src_a_val_q <= map_a_val;
		end
		if (load) begin
			out_src_a_q      <= o_src_a;
			out_src_b_q      <= o_src_b;
			out_flags_src_q  <= o_flags_src;
			out_dest_q       <= o_dest;
			out_flags_dest_q <= o_flags_dest;
			out_prev_q       <= o_prev;
			out_prev_flags_q <= o_prev_flags;
			out_oor_q        <= o_oor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			flags_map_q <= PW'(ARCH_REGS - 1);
			head_q      <= '0;
			tail_q      <= PW'(INIT_FREE % PHYS_REGS);
			count_q     <= CW'(INIT_FREE);
			head_lap_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= (q_item.kind == rru_pkg::KIND_RELEASE) ? ST_PUSH1 : ST_RD_DEST;
					end
				end
				ST_RD_DEST: state_q <= ST_EXEC;
				ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_PUSH1: state_q <= ST_PUSH2;
				ST_PUSH2: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (commit) begin
				head_q  <= head_new;
				count_q <= count_q - CW'(need);
				if (head_wrap) begin
					head_lap_q <= 1'b1;
				end
				if (cur_q.wf) begin
					flags_map_q <= cur_q.d_ok ? fifo_b_val : fifo_a_val;
				end else if (cur_q.d_ok && d_flag) begin
					flags_map_q <= fifo_a_val;
				end
			end
			if (fifo_we) begin
				tail_q  <= tail_nxt;
				count_q <= count_q + CW'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid    = out_valid_q;
	assign phys_src_a      = out_src_a_q;
	assign phys_src_b      = out_src_b_q;
	assign phys_flags_src  = out_flags_src_q;
	assign phys_dest       = out_dest_q;
	assign phys_flags_dest = out_flags_dest_q;
	assign prev_dest       = out_prev_q;
	assign prev_flags_dest = out_prev_flags_q;
	assign out_of_regs     = out_oor_q;

endmodule

`default_nettype wire

// ===== rtl/core/register_rename_unit.sv =====
// A rename reads its sources and then its destination through two map table read ports;
// a release writes its two released registers to the free list through one write port.
// The back end takes no new word before it is done with the last. A two-word input queue
// keeps accepting until full while the back end or the output is stalled. Reset is
// asynchronous and active low: the map table is identity at once through per-entry valid
// bits and the free list holds its initial registers without a sweep.
`default_nettype none

module register_rename_unit #(
	parameter int ARCH_REGS = 50,
	parameter int PHYS_REGS = 512
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    item_valid,
	output logic                                         item_ready,
	input  wire logic                                    kind,
	input  wire logic signed [rru_pkg::ARCH_FIELD_W-1:0] src_a,
	input  wire logic signed [rru_pkg::ARCH_FIELD_W-1:0] src_b,
	input  wire logic signed [rru_pkg::ARCH_FIELD_W-1:0] dest,
	input  wire logic                                    reads_flags,
	input  wire logic                                    writes_flags,
	input  wire logic signed [rru_pkg::PHYS_FIELD_W-1:0] release_first,
	input  wire logic signed [rru_pkg::PHYS_FIELD_W-1:0] release_second,
	output logic                                         result_valid,
	input  wire logic                                    result_ready,
	output logic signed [rru_pkg::PHYS_FIELD_W-1:0]      phys_src_a,
	output logic signed [rru_pkg::PHYS_FIELD_W-1:0]      phys_src_b,
	output logic signed [rru_pkg::PHYS_FIELD_W-1:0]      phys_flags_src,
	output logic signed [rru_pkg::PHYS_FIELD_W-1:0]      phys_dest,
	output logic signed [rru_pkg::PHYS_FIELD_W-1:0]      phys_flags_dest,
	output logic signed [rru_pkg::PHYS_FIELD_W-1:0]      prev_dest,
	output logic signed [rru_pkg::PHYS_FIELD_W-1:0]      prev_flags_dest,
	output logic                                         out_of_regs
);

	logic               q_valid;
	logic               q_pop;
	rru_pkg::rru_item_t q_item;

	rru_front #(
		.ARCH_REGS(ARCH_REGS),
		.PHYS_REGS(PHYS_REGS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.kind           (kind),
		.src_a          (src_a),
		.src_b          (src_b),
		.dest           (dest),
		.reads_flags    (reads_flags),
		.writes_flags   (writes_flags),
		.release_first  (release_first),
		.release_second (release_second),
		.q_valid        (q_valid),
		.q_pop          (q_pop),
		.q_item         (q_item)
	);

	rru_back #(
		.ARCH_REGS(ARCH_REGS),
		.PHYS_REGS(PHYS_REGS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_pop           (q_pop),
		.q_item          (q_item),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.phys_src_a      (phys_src_a),
		.phys_src_b      (phys_src_b),
		.phys_flags_src  (phys_flags_src),
		.phys_dest       (phys_dest),
		.phys_flags_dest (phys_flags_dest),
		.prev_dest       (prev_dest),
		.prev_flags_dest (prev_flags_dest),
		.out_of_regs     (out_of_regs)
	);

endmodule

`default_nettype wire

// ===== rtl/core/rru_checker.sv =====
// Port-level checks of the register rename unit and their bind statement.
`default_nettype none
`include "register_rename_unit_defines.svh"

module rru_checker (
	input wire logic                                    clk,
	input wire logic                                    arst_n,
	input wire logic                                    result_valid,
	input wire logic                                    result_ready,
	input wire logic signed [rru_pkg::PHYS_FIELD_W-1:0] phys_src_a,
	input wire logic signed [rru_pkg::PHYS_FIELD_W-1:0] phys_dest,
	input wire logic signed [rru_pkg::PHYS_FIELD_W-1:0] phys_flags_dest,
	input wire logic signed [rru_pkg::PHYS_FIELD_W-1:0] prev_dest,
	input wire logic signed [rru_pkg::PHYS_FIELD_W-1:0] prev_flags_dest,
	input wire logic                                    out_of_regs
);

	`RRU_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(phys_dest) && $stable(prev_dest) && $stable(out_of_regs), "stalled result word changed or dropped")
	`RRU_ASSERT_NOW(a_refused_empty, result_valid && out_of_regs, phys_src_a == rru_pkg::NONE_PHYS && phys_dest == rru_pkg::NONE_PHYS && phys_flags_dest == rru_pkg::NONE_PHYS, "refused rename carries register numbers")
	`RRU_ASSERT_NOW(a_dest_pair, result_valid, (phys_dest == rru_pkg::NONE_PHYS) == (prev_dest == rru_pkg::NONE_PHYS), "new and previous destination disagree")
	`RRU_ASSERT_NOW(a_flags_pair, result_valid, (phys_flags_dest == rru_pkg::NONE_PHYS) == (prev_flags_dest == rru_pkg::NONE_PHYS), "new and previous flags mapping disagree")

endmodule

bind register_rename_unit rru_checker u_rru_checker (.*);

`default_nettype wire
